@@ src/i2cms_pkg.sv @@
// Shared types, status codes and helpers for the I2C master transfer sequencer.
// No dependencies; used by i2cms_action and i2c_master_transfer_sequencer_core.
package i2cms_pkg;

   typedef enum logic [2:0] {
      PHASE_IDLE     = 3'd0,
      PHASE_ADDRESS  = 3'd1,
      PHASE_TRANSMIT = 3'd2,
      PHASE_RECEIVE  = 3'd3,
      PHASE_ERROR    = 3'd4
   } phase_type;

   localparam logic [1:0] FUNC_START_READ  = 2'd0;
   localparam logic [1:0] FUNC_START_WRITE = 2'd1;
   localparam logic [1:0] FUNC_STATUS      = 2'd2;

   localparam logic [7:0] ST_START        = 8'h08;
   localparam logic [7:0] ST_RESTART      = 8'h10;
   localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
   localparam logic [7:0] ST_ADDR_W_NACK  = 8'h20;
   localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST     = 8'h38;
   localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
   localparam logic [7:0] ST_ADDR_R_NACK  = 8'h48;
   localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

   localparam logic CSR_TARGET_ADDRESS   = 1'b0;
   localparam logic CSR_STOP_AFTER_WRITE = 1'b1;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] tx_remaining;
      logic [15:0] rx_remaining;
   } seq_state_type;

   typedef struct packed {
      logic [7:0] target_address_byte;
      logic       stop_after_write;
   } seq_cfg_type;

   typedef struct packed {
      phase_type  bus_phase;
      logic       data_load;
      logic [7:0] data_value;
      logic       request_start;
      logic       clear_start;
      logic       request_stop;
      logic       set_ack;
      logic       clear_ack;
      logic       receive_valid;
      logic [7:0] receive_data;
      logic       transfer_done;
      logic       clear_interrupt;
   } seq_action_type;

   function automatic logic [15:0] count_down(input logic [15:0] value);
      count_down = (value == 16'd0) ? 16'd0 : value - 16'd1;
   endfunction

endpackage

@@ src/i2cms_action.sv @@
// Action decoder: next sequencer state and engine action set for one item.
// Depends on i2cms_pkg.
module i2cms_action (
   input  logic [1:0]               func,
   input  logic [15:0]              byte_count,
   input  logic [7:0]               bus_status,
   input  logic [7:0]               received_byte,
   input  logic [7:0]               next_transmit_byte,
   input  i2cms_pkg::seq_cfg_type    cfg,
   input  i2cms_pkg::seq_state_type  state_cur,
   output i2cms_pkg::seq_state_type  state_nxt,
   output i2cms_pkg::seq_action_type action
);

   logic [15:0] tx_dec;
   logic [15:0] rx_dec;

   assign tx_dec = i2cms_pkg::count_down(state_cur.tx_remaining);
   assign rx_dec = i2cms_pkg::count_down(state_cur.rx_remaining);

   always_comb begin
      state_nxt = state_cur;
      action    = '0;
      case (func) inside
         i2cms_pkg::FUNC_START_READ, i2cms_pkg::FUNC_START_WRITE: begin
            state_nxt.rx_remaining = (func == i2cms_pkg::FUNC_START_READ) ? byte_count : 16'd0;
            state_nxt.tx_remaining = (func == i2cms_pkg::FUNC_START_WRITE) ? byte_count : 16'd0;
            state_nxt.phase        = i2cms_pkg::PHASE_ADDRESS;
            action.request_start   = 1'b1;
         end
         i2cms_pkg::FUNC_STATUS: begin
            action.clear_interrupt = 1'b1;
            case (bus_status) inside
               i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART: begin
                  action.data_load   = 1'b1;
                  action.data_value  = {cfg.target_address_byte[7:1],
                                        cfg.target_address_byte[0]
                                        | (state_cur.tx_remaining == 16'd0)};
                  action.clear_start = 1'b1;
               end
               i2cms_pkg::ST_ADDR_W_ACK: begin
                  state_nxt.tx_remaining = tx_dec;
                  action.data_load       = 1'b1;
                  action.data_value      = next_transmit_byte;
                  state_nxt.phase        = i2cms_pkg::PHASE_TRANSMIT;
               end
               i2cms_pkg::ST_ADDR_R_ACK: begin
                  action.clear_ack = (state_cur.rx_remaining == 16'd1);
                  action.set_ack   = (state_cur.rx_remaining != 16'd1);
                  state_nxt.phase  = i2cms_pkg::PHASE_RECEIVE;
               end
               i2cms_pkg::ST_DATA_TX_ACK, i2cms_pkg::ST_DATA_TX_NACK: begin
                  if (state_cur.tx_remaining != 16'd0) begin
                     action.data_load       = 1'b1;
                     action.data_value      = next_transmit_byte;
                     state_nxt.tx_remaining = tx_dec;
                  end else begin
                     action.request_stop  = cfg.stop_after_write;
                     state_nxt.phase      = i2cms_pkg::PHASE_IDLE;
                     action.transfer_done = 1'b1;
                  end
               end
               i2cms_pkg::ST_DATA_RX_ACK: begin
                  state_nxt.rx_remaining = rx_dec;
                  action.receive_valid   = 1'b1;
                  action.receive_data    = received_byte;
                  action.clear_ack       = (rx_dec == 16'd1);
                  action.set_ack         = (rx_dec != 16'd1);
               end
               i2cms_pkg::ST_DATA_RX_NACK: begin
                  state_nxt.rx_remaining = rx_dec;
                  action.receive_valid   = 1'b1;
                  action.receive_data    = received_byte;
                  action.request_stop    = 1'b1;
                  state_nxt.phase        = i2cms_pkg::PHASE_IDLE;
                  action.transfer_done   = 1'b1;
               end
               i2cms_pkg::ST_ARB_LOST, i2cms_pkg::ST_ADDR_W_NACK,
               i2cms_pkg::ST_ADDR_R_NACK: begin
                  action.request_stop  = 1'b1;
                  state_nxt.phase      = i2cms_pkg::PHASE_ERROR;
                  action.transfer_done = 1'b1;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      action.bus_phase = state_nxt.phase;
   end

endmodule

@@ src/i2c_master_transfer_sequencer_core.sv @@
// Top level of the I2C master transfer sequencer: request register, sequencer
// state, result register and APB-style register port. Depends on i2cms_pkg, i2cms_action.
//
//   channel | prefix | handshake              | payload
//   request | req_   | req_valid / req_ready  | func, byte_count, bus_status, bytes
//   result  | rsp_   | rsp_valid / rsp_ready  | action set and bus_phase
//   config  | csr_   | psel, penable, pwrite  | paddr[2] selects register
//
// One item per cycle sustained while rsp_ready stays high; an item is captured in the
// request register, then moves into the result register, which offers it.
// The sequencer state advances when an item moves from the request register
// into the result register, so a stalled result holds the state too.
// Reset clears both valid flags and the sequencer state and sets the config defaults.
module i2c_master_transfer_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_byte_count,
   input  logic [7:0]  req_bus_status,
   input  logic [7:0]  req_received_byte,
   input  logic [7:0]  req_next_transmit_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_bus_phase,
   output logic        rsp_data_load,
   output logic [7:0]  rsp_data_value,
   output logic        rsp_request_start,
   output logic        rsp_clear_start,
   output logic        rsp_request_stop,
   output logic        rsp_set_ack,
   output logic        rsp_clear_ack,
   output logic        rsp_receive_valid,
   output logic [7:0]  rsp_receive_data,
   output logic        rsp_transfer_done,
   output logic        rsp_clear_interrupt,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                      req_hold_ff;
   logic [1:0]                req_func_ff;
   logic [15:0]               req_byte_count_ff;
   logic [7:0]                req_bus_status_ff;
   logic [7:0]                req_received_byte_ff;
   logic [7:0]                req_next_transmit_byte_ff;
   logic                      rsp_valid_ff;
   i2cms_pkg::seq_action_type rsp_ff;
   i2cms_pkg::seq_action_type rsp_in;
   i2cms_pkg::seq_state_type  state_ff;
   i2cms_pkg::seq_state_type  state_in;
   i2cms_pkg::seq_cfg_type    cfg_ff;
   logic                      advance;
   logic                      req_xfer;
   logic                      csr_write;

   assign advance   = req_hold_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_hold_ff || advance;
   assign req_xfer  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   i2cms_action u_action (
      .func               (req_func_ff),
      .byte_count         (req_byte_count_ff),
      .bus_status         (req_bus_status_ff),
      .received_byte      (req_received_byte_ff),
      .next_transmit_byte (req_next_transmit_byte_ff),
      .cfg                (cfg_ff),
      .state_cur          (state_ff),
      .state_nxt          (state_in),
      .action             (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_hold_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: i2cms_pkg::PHASE_IDLE, tx_remaining: 16'd0,
                           rx_remaining: 16'd0};
      end else begin
         if (req_ready) begin
            req_hold_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_func_ff               <= req_func;
         req_byte_count_ff         <= req_byte_count;
         req_bus_status_ff         <= req_bus_status;
         req_received_byte_ff      <= req_received_byte;
         req_next_transmit_byte_ff <= req_next_transmit_byte;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{target_address_byte: 8'd0, stop_after_write: 1'b1};
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            i2cms_pkg::CSR_TARGET_ADDRESS: begin
               cfg_ff.target_address_byte <= csr_pwdata[7:0];
            end
            i2cms_pkg::CSR_STOP_AFTER_WRITE: begin
               cfg_ff.stop_after_write <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         i2cms_pkg::CSR_TARGET_ADDRESS:   csr_prdata = {24'd0, cfg_ff.target_address_byte};
         i2cms_pkg::CSR_STOP_AFTER_WRITE: csr_prdata = {31'd0, cfg_ff.stop_after_write};
         default:                         csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bus_phase       = rsp_ff.bus_phase;
   assign rsp_data_load       = rsp_ff.data_load;
   assign rsp_data_value      = rsp_ff.data_value;
   assign rsp_request_start   = rsp_ff.request_start;
   assign rsp_clear_start     = rsp_ff.clear_start;
   assign rsp_request_stop    = rsp_ff.request_stop;
   assign rsp_set_ack         = rsp_ff.set_ack;
   assign rsp_clear_ack       = rsp_ff.clear_ack;
   assign rsp_receive_valid   = rsp_ff.receive_valid;
   assign rsp_receive_data    = rsp_ff.receive_data;
   assign rsp_transfer_done   = rsp_ff.transfer_done;
   assign rsp_clear_interrupt = rsp_ff.clear_interrupt;

endmodule
